// ----- sv/mfr_pkg.sv -----
package mfr_pkg;

  // bytes carried per motor in a feedback frame
  localparam int BYTES_PER_MOTOR = 5;

  // frame queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // widths of the packed stream payloads and of the per-motor byte counter
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int SUB_W       = 3;

  // register byte addresses
  localparam logic REG_HEADER_BYTE = 1'b0;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_EMIT
  } back_state_t;

  // one finished frame waiting for readout
  typedef struct packed {
    logic ok;
    logic bank;
  } q_entry_t;

  // back part hands a store bank back to the front
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

endpackage

// ----- sv/mfr_queue.sv -----
module mfr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mfr_pkg::q_entry_t push_entry,
  input  logic              pop,
  output mfr_pkg::q_entry_t head,
  output logic              full,
  output logic              empty
);

  mfr_pkg::q_entry_t                  entries [mfr_pkg::QDEPTH];
  logic [mfr_pkg::QPTR_W-1:0]         wr_ptr;
  logic [mfr_pkg::QPTR_W-1:0]         rd_ptr;
  logic [mfr_pkg::QCNT_W-1:0]         count;

  assign full  = (count == mfr_pkg::QCNT_W'(mfr_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- sv/mfr_front.sv -----
module mfr_front #(
  parameter int MOTOR_COUNT = 14,
  localparam int PL = mfr_pkg::BYTES_PER_MOTOR * MOTOR_COUNT,
  localparam int AW = $clog2(2 * PL),
  localparam int PW = $clog2(PL + 2)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               header_byte,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               rx_byte,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [7:0]               wr_data,
  output logic                     q_push,
  output mfr_pkg::q_entry_t        q_entry,
  input  logic                     q_full,
  input  mfr_pkg::bank_release_t   release_bank
);

  logic [PW-1:0] byte_position;
  logic [7:0]    running_xor;
  logic          bank;
  logic [1:0]    busy;
  logic          in_payload;
  logic          at_check;
  logic          accept;
  logic          check_ok;
  logic [AW-1:0] bank_base;

  assign in_payload = (byte_position != '0) && (byte_position <= PW'(PL));
  assign at_check   = (byte_position == PW'(PL + 1));

  // hold off payload bytes while their bank still waits for readout, the check byte while the queue is full
  assign in_ready = !(in_payload && busy[bank]) && !(at_check && q_full);
  assign accept   = in_valid && in_ready;
  assign check_ok = (rx_byte == running_xor);

  // store write for payload bytes
  assign bank_base = bank ? AW'(PL) : '0;
  assign wr_en     = accept && in_payload;
  assign wr_addr   = bank_base + AW'(byte_position - PW'(1));
  assign wr_data   = rx_byte;

  // frame result to the queue on the check byte
  assign q_push        = accept && at_check;
  assign q_entry.ok    = check_ok;
  assign q_entry.bank  = bank;

  // frame position, running check, bank ownership
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_xor   <= '0;
      bank          <= 1'b0;
      busy          <= '0;
    end else begin
      if (release_bank.valid) begin
        busy[release_bank.bank] <= 1'b0;
      end
      if (accept) begin
        if (byte_position == '0) begin
          if (rx_byte == header_byte) begin
            running_xor   <= rx_byte;
            byte_position <= PW'(1);
          end
        end else if (in_payload) begin
          running_xor   <= running_xor ^ rx_byte;
          byte_position <= byte_position + PW'(1);
        end else begin
          running_xor   <= '0;
          byte_position <= '0;
          if (check_ok) begin
            busy[bank] <= 1'b1;
            bank       <= ~bank;
          end
        end
      end
    end
  end

endmodule

// ----- sv/mfr_back.sv -----
module mfr_back #(
  parameter int MOTOR_COUNT = 14,
  localparam int PL = mfr_pkg::BYTES_PER_MOTOR * MOTOR_COUNT,
  localparam int AW = $clog2(2 * PL),
  localparam int MW = $clog2(MOTOR_COUNT + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [7:0]               wr_data,
  input  mfr_pkg::q_entry_t        q_head,
  input  logic                     q_empty,
  output logic                     q_pop,
  output mfr_pkg::bank_release_t   release_bank,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0]               motor_slot,
  output logic [15:0]              position_code,
  output logic [11:0]              velocity_code,
  output logic [11:0]              torque_code,
  output logic                     frame_ok,
  output logic                     last_record
);

  mfr_pkg::back_state_t        state;
  mfr_pkg::back_state_t        state_next;
  logic [7:0]                  store [2 * PL];
  logic [7:0]                  rd_data;
  logic                        rd_en;
  logic [AW-1:0]               ptr;
  logic [mfr_pkg::SUB_W-1:0]   sub;
  logic [MW-1:0]               motor;
  logic [MW+3:0]               motor_ext;
  logic [7:0]                  sh [4];
  logic                        cur_ok;
  logic                        cur_bank;
  logic                        sub_done;
  logic                        out_take;

  assign sub_done  = (sub == mfr_pkg::SUB_W'(mfr_pkg::BYTES_PER_MOTOR));
  assign out_take  = out_valid && out_ready;
  assign motor_ext = {4'b0, motor};

  // payload store, both banks, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store[ptr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mfr_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_next = q_head.ok ? mfr_pkg::B_FETCH : mfr_pkg::B_EMIT;
        end
      end
      mfr_pkg::B_FETCH: begin
        if (sub_done) begin
          state_next = mfr_pkg::B_EMIT;
        end
      end
      mfr_pkg::B_EMIT: begin
        if (out_take) begin
          state_next = last_record ? mfr_pkg::B_IDLE : mfr_pkg::B_FETCH;
        end
      end
      default: state_next = mfr_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    rd_en              = 1'b0;
    out_valid          = 1'b0;
    q_pop              = 1'b0;
    release_bank.valid = 1'b0;
    release_bank.bank  = cur_bank;
    case (state)
      mfr_pkg::B_IDLE: begin
      end
      mfr_pkg::B_FETCH: begin
        rd_en = !sub_done;
      end
      mfr_pkg::B_EMIT: begin
        out_valid = 1'b1;
        if (out_take && last_record) begin
          q_pop              = 1'b1;
          release_bank.valid = cur_ok;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfr_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // readout datapath: five byte reads per motor, then the record
  always_ff @(posedge clk) begin
    case (state)
      mfr_pkg::B_IDLE: begin
        if (!q_empty) begin
          cur_ok   <= q_head.ok;
          cur_bank <= q_head.bank;
          ptr      <= q_head.bank ? AW'(PL) : '0;
          sub      <= '0;
          motor    <= '0;
          if (!q_head.ok) begin
            motor_slot    <= '0;
            position_code <= '0;
            velocity_code <= '0;
            torque_code   <= '0;
            frame_ok      <= 1'b0;
            last_record   <= 1'b1;
          end
        end
      end
      mfr_pkg::B_FETCH: begin
        if (!sub_done) begin
          ptr <= ptr + AW'(1);
          sub <= sub + mfr_pkg::SUB_W'(1);
        end
        // shift in bytes 0..3 as they come back
        if (sub != '0 && !sub_done) begin
          sh[0] <= sh[1];
          sh[1] <= sh[2];
          sh[2] <= sh[3];
          sh[3] <= rd_data;
        end
        if (sub_done) begin
          motor_slot    <= motor_ext[3:0];
          position_code <= {sh[0], sh[1]};
          velocity_code <= {sh[2], sh[3][7:4]};
          torque_code   <= {sh[3][3:0], rd_data};
          frame_ok      <= 1'b1;
          last_record   <= (motor == MW'(MOTOR_COUNT - 1));
        end
      end
      mfr_pkg::B_EMIT: begin
        if (out_take && !last_record) begin
          motor <= motor + MW'(1);
          sub   <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/motor_feedback_frame_receiver_core.sv -----
// Motor feedback frame receiver. Serial bytes enter on the s_ stream, one per beat; while no
// frame is open, bytes other than the header_byte register value are dropped. A frame is the
// header, five bytes per motor and a check byte equal to the XOR of all bytes before it. A good
// frame yields one record per motor on the m_ stream (tlast on the final one); a bad one yields
// a single record with frame_ok low and tlast high. Input takes one byte per cycle while a frame
// is collected, unless stalled; the store holds two frames, so a payload byte stalls while the
// bank it would go to still waits for readout, and a check byte stalls while two finished frames
// already wait in the frame queue. Readout runs through the single read port of the store: after
// the frame is picked up from the queue, each motor record takes five byte reads, an assemble
// step and an output beat, and the output beat waits while the output is stalled; an error
// record needs no store reads. The store needs no clearing after reset.
module motor_feedback_frame_receiver_core #(
  parameter int MOTOR_COUNT = 14
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [3:0] motor_slot, [19:4] position_code,
                                 // [31:20] velocity_code, [43:32] torque_code, [47:44] zero
  output logic        m_tuser,   // [0] frame_ok
  output logic        m_tlast,   // last_record
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PL = mfr_pkg::BYTES_PER_MOTOR * MOTOR_COUNT;
  localparam int AW = $clog2(2 * PL);

  logic [7:0]             header_byte;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [7:0]             wr_data;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  mfr_pkg::q_entry_t      q_entry;
  mfr_pkg::q_entry_t      q_head;
  mfr_pkg::bank_release_t release_bank;
  logic [3:0]             motor_slot;
  logic [15:0]            position_code;
  logic [11:0]            velocity_code;
  logic [11:0]            torque_code;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mfr_pkg::REG_HEADER_BYTE) ? {24'b0, header_byte} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mfr_pkg::REG_HEADER_BYTE) begin
      header_byte <= pwdata[7:0];
    end
  end

  mfr_front #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .header_byte  (header_byte),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .rx_byte      (s_tdata),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .q_push       (q_push),
    .q_entry      (q_entry),
    .q_full       (q_full),
    .release_bank (release_bank)
  );

  mfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  mfr_back #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .release_bank  (release_bank),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .motor_slot    (motor_slot),
    .position_code (position_code),
    .velocity_code (velocity_code),
    .torque_code   (torque_code),
    .frame_ok      (m_tuser),
    .last_record   (m_tlast)
  );

  // pack the record beat
  assign m_tdata = {4'b0, torque_code, velocity_code, position_code, motor_slot};

endmodule

// ----- tb/motor_feedback_frame_receiver_core_tb.sv -----
module motor_feedback_frame_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MOTORS        = 14;
  localparam int PAYLOAD_BYTES = mfr_pkg::BYTES_PER_MOTOR * MOTORS;
  localparam int CHECK_POS     = PAYLOAD_BYTES + 1;
  localparam int SETTLE        = 8 * MOTORS + 50;
  localparam int LIMIT         = 200000;
  localparam int REPORT_MAX    = 10;
  localparam int IDLE_PCT      = 21;

  // register indexes and byte addresses
  localparam int          IDX_HEADER  = 0;
  localparam logic [2:0]  ADDR_HEADER = {mfr_pkg::REG_HEADER_BYTE, 2'b00};
  localparam logic [2:0]  ADDR_SPARE  = 3'd4;

  // one motor record as it leaves the block
  typedef struct packed {
    logic [3:0]  slot;
    logic [15:0] pos;
    logic [11:0] vel;
    logic [11:0] tor;
    logic        ok;
    logic        last;
  } rec_t;

  // frame assembler model plus the records it still owes
  class record_board;
    bit [7:0]    header;
    int unsigned fill;
    bit [7:0]    xr;
    bit [7:0]    payload [PAYLOAD_BYTES];
    rec_t        pending_records [$];
    int unsigned errors;

    function void write_reg(int unsigned idx, bit [31:0] v);
      if (idx == IDX_HEADER) header = v[7:0];
    endfunction

    function string fmt(rec_t r);
      return $sformatf("slot %0d pos %h vel %h tor %h ok %b last %b",
                       r.slot, r.pos, r.vel, r.tor, r.ok, r.last);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // accepted input beat
    function void absorb_byte(bit [7:0] b);
      rec_t r;
      int   m;
      int   k;
      if (fill == 0) begin
        if (b == header) begin
          xr = b;
          fill = 1;
        end
        return;
      end
      if (fill <= PAYLOAD_BYTES) begin
        payload[fill - 1] = b;
        xr ^= b;
        fill++;
        return;
      end
      // check byte closes the frame
      fill = 0;
      if (b != xr) begin
        r = '0;
        r.last = 1'b1;
        pending_records.insert(pending_records.size(), r);
      end else begin
        for (m = 0; m < MOTORS; m++) begin
          k = m * mfr_pkg::BYTES_PER_MOTOR;
          r.slot = 4'(m);
          r.pos  = {payload[k], payload[k + 1]};
          r.vel  = {payload[k + 2], payload[k + 3][7:4]};
          r.tor  = {payload[k + 3][3:0], payload[k + 4]};
          r.ok   = 1'b1;
          r.last = (m == MOTORS - 1);
          pending_records.insert(pending_records.size(), r);
        end
      end
      xr = 0;
    endfunction

    // accepted output beat
    function void match_record(rec_t act);
      rec_t e;
      if (pending_records.size() == 0) begin
        note_error({"record with none expected: ", fmt(act)});
        return;
      end
      e = pending_records.pop_front();
      if (e.slot !== act.slot || e.pos !== act.pos || e.vel !== act.vel ||
          e.tor !== act.tor || e.ok !== act.ok || e.last !== act.last)
        note_error({"expected ", fmt(e), " got ", fmt(act)});
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;    // [3:0] slot, [19:4] pos, [31:20] vel, [43:32] tor
  logic        m_tuser;    // [0] frame_ok
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  record_board board;
  bit          steady;
  int          hold_cycles;
  int unsigned cycles;

  motor_feedback_frame_receiver_core #(
    .MOTOR_COUNT(MOTORS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("motor_feedback_frame_receiver_core_tb: done, errors");
      $finish;
    end
  end

  // output side ready, with random stalls and a long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare every output beat
  always @(posedge clk) begin
    rec_t act;
    if (!rst && m_tvalid && m_tready) begin
      act.slot = m_tdata[3:0];
      act.pos  = m_tdata[19:4];
      act.vel  = m_tdata[31:20];
      act.tor  = m_tdata[43:32];
      act.ok   = m_tuser;
      act.last = m_tlast;
      board.match_record(act);
    end
  end

  // one input beat, entered and left at a falling edge
  task automatic send_byte(input bit [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    board.absorb_byte(b);
    @(negedge clk);
  endtask

  // bytes dropped while no frame is open
  task automatic send_noise(input int n);
    bit [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (b == board.header) b = b ^ 8'h01;
      send_byte(b);
    end
  endtask

  // open or continue a frame, up to max_bytes beats, optional bad check byte
  task automatic run_frame(input bit corrupt, input int max_bytes);
    int       n;
    bit [7:0] b;
    n = 0;
    if (board.fill == 0) begin
      send_byte(board.header);
      n++;
    end
    while (board.fill != 0 && n < max_bytes) begin
      if (board.fill == CHECK_POS)
        b = corrupt ? board.xr ^ 8'($urandom_range(1, 255)) : board.xr;
      else if ($urandom_range(7) == 0)
        b = board.header;
      else
        b = 8'($urandom);
      send_byte(b);
      n++;
    end
  endtask

  // register write: setup then access
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(addr >> 2, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // read back the header register
  task automatic check_header_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_HEADER;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== board.header)
      board.note_error($sformatf("header reg expected %h got %h", board.header, prdata[7:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering input, wait for every owed record, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (board.pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // main sequence
  initial begin
    bit [7:0] frame [PAYLOAD_BYTES];
    int       i;
    board       = new;
    steady      = 1'b0;
    hold_cycles = 0;
    cycles      = 0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset header value, junk before the frame is dropped
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h7F);

    // output held off while two frames fill both banks and a third stalls
    hold_cycles = 400;

    // extreme field values, header value inside the payload
    for (i = 0; i < PAYLOAD_BYTES; i++) frame[i] = 8'(i * 37 + 11);
    for (i = 0; i < 5; i++) frame[i] = 8'hFF;
    for (i = 5; i < 10; i++) frame[i] = 8'h00;
    frame[10] = 8'h00;
    frame[11] = 8'h80;
    frame[12] = 8'h01;
    frame[13] = 8'hF0;
    frame[14] = 8'h0F;
    frame[15] = 8'h01;
    frame[16] = 8'h00;
    frame[17] = 8'hFF;
    frame[18] = 8'h0F;
    frame[19] = 8'hF0;
    send_byte(board.header);
    for (i = 0; i < PAYLOAD_BYTES; i++) send_byte(frame[i]);
    send_byte(board.xr);

    // no idling on either side, second frame, then a third left open
    steady = 1'b1;
    run_frame(1'b0, 1000);
    run_frame(1'b0, 12);
    wait_idle();
    steady = 1'b0;

    // all-ones header written with a frame open, spare address ignored
    apb_write(ADDR_HEADER, 32'h0000_00FF);
    apb_write(ADDR_SPARE, 32'h0000_005A);
    check_header_reg();

    // finish the open frame with a bad check byte, then junk is dropped
    run_frame(1'b1, 1000);
    send_noise(3);
    wait_idle();

    if (board.pending_records.size() != 0)
      board.note_error($sformatf("%0d records never arrived", board.pending_records.size()));
    if (board.errors == 0)
      $display("motor_feedback_frame_receiver_core_tb: done, clean");
    else
      $display("motor_feedback_frame_receiver_core_tb: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mfr_pkg.sv
sv/mfr_queue.sv
sv/mfr_front.sv
sv/mfr_back.sv
sv/motor_feedback_frame_receiver_core.sv
tb/motor_feedback_frame_receiver_core_tb.sv
